FILE: rtl/core/spt_pkg.sv
`timescale 1ns / 1ps

package spt_pkg;

  localparam int DEF_MAX_BONES = 256;
  localparam int WORDS = 10;
  localparam logic [8:0] NO_PARENT = 9'd256;
  localparam logic [30:0] MIN_SCALE_RST = 31'd17;
  localparam logic [5:0] MAC_TERMS = 6'd37;
  localparam int DIV_BITS = 56;
  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  typedef enum logic [0:0] {
    CFG_DIRECTION = 1'b0,
    CFG_MIN_SCALE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]         bone_index;
    logic [8:0]         parent_index;
    logic signed [31:0] rot_w;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic signed [31:0] scale_x;
    logic signed [31:0] scale_y;
    logic signed [31:0] scale_z;
    logic signed [31:0] move_x;
    logic signed [31:0] move_y;
    logic signed [31:0] move_z;
  } item_t;

  typedef struct packed {
    logic [7:0]         out_bone;
    logic signed [31:0] out_rot_w;
    logic signed [31:0] out_rot_x;
    logic signed [31:0] out_rot_y;
    logic signed [31:0] out_rot_z;
    logic signed [31:0] out_scale_x;
    logic signed [31:0] out_scale_y;
    logic signed [31:0] out_scale_z;
    logic signed [31:0] out_move_x;
    logic signed [31:0] out_move_y;
    logic signed [31:0] out_move_z;
    logic               scale_error;
  } result_t;

  // operand sources of the shared multiplier
  typedef enum logic [2:0] {
    SRC_PAR = 3'd0,
    SRC_ITM = 3'd1,
    SRC_QR  = 3'd2,
    SRC_VV  = 3'd3,
    SRC_UV  = 3'd4
  } src_grp_t;

  // accumulator destinations
  typedef enum logic [2:0] {
    DST_RES = 3'd0,
    DST_VV  = 3'd1,
    DST_UV  = 3'd2,
    DST_UUV = 3'd3,
    DST_RW  = 3'd4
  } dst_grp_t;

  typedef struct packed {
    src_grp_t   grp;
    logic [3:0] idx;
  } src_t;

  typedef struct packed {
    dst_grp_t   grp;
    logic [3:0] idx;
  } dst_t;

  typedef struct packed {
    src_t a;
    src_t b;
    logic neg;
    logic first;
    logic last;
    logic sh24;
    logic fwd;
    dst_t d;
  } mop_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7fffffff;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = $signed(v[31:0]);
    return r;
  endfunction

  // hamilton product term tables: output o, term t
  function automatic logic [1:0] qm_a(input logic [1:0] o, input logic [1:0] t);
    logic [1:0] r;
    case (o)
      2'd2: case (t) 2'd0: r = 2'd0; 2'd1: r = 2'd2; 2'd2: r = 2'd3; default: r = 2'd1; endcase
      2'd3: case (t) 2'd0: r = 2'd0; 2'd1: r = 2'd3; 2'd2: r = 2'd1; default: r = 2'd2; endcase
      default: r = t;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] qm_b(input logic [1:0] o, input logic [1:0] t);
    logic [1:0] r;
    case (o)
      2'd1: case (t) 2'd0: r = 2'd1; 2'd1: r = 2'd0; 2'd2: r = 2'd3; default: r = 2'd2; endcase
      2'd2: case (t) 2'd0: r = 2'd2; 2'd1: r = 2'd0; 2'd2: r = 2'd1; default: r = 2'd3; endcase
      2'd3: case (t) 2'd0: r = 2'd3; 2'd1: r = 2'd0; 2'd2: r = 2'd2; default: r = 2'd1; endcase
      default: r = t;
    endcase
    return r;
  endfunction

  // cross product term tables: component o, term t
  function automatic logic [1:0] cr_u(input logic [1:0] o, input logic t);
    logic [1:0] r;
    case (o)
      2'd0: r = t ? 2'd2 : 2'd1;
      2'd1: r = t ? 2'd0 : 2'd2;
      default: r = t ? 2'd1 : 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] cr_v(input logic [1:0] o, input logic t);
    logic [1:0] r;
    case (o)
      2'd0: r = t ? 2'd1 : 2'd2;
      2'd1: r = t ? 2'd2 : 2'd0;
      default: r = t ? 2'd0 : 2'd1;
    endcase
    return r;
  endfunction

  // multiply-accumulate schedule, one product per step
  function automatic mop_t spt_decode(input logic [5:0] k);
    mop_t m;
    logic [5:0] j;
    m = '0;
    j = '0;
    if (k < 6'd3) begin
      j = k;
      m.a = '{SRC_PAR, 4'(j + 6'd4)};
      m.b = '{SRC_ITM, 4'(j + 6'd7)};
      m.first = 1'b1; m.last = 1'b1; m.sh24 = 1'b1; m.fwd = 1'b1;
      m.d = '{DST_VV, j[3:0]};
    end else if (k < 6'd19) begin
      j = k - 6'd3;
      m.a = '{SRC_QR, {2'b0, qm_a(j[3:2], j[1:0])}};
      m.b = '{SRC_ITM, {2'b0, qm_b(j[3:2], j[1:0])}};
      m.neg = (j[3:2] == 2'd0) ? (j[1:0] != 2'd0) : (j[1:0] == 2'd3);
      m.first = (j[1:0] == 2'd0);
      m.last = (j[1:0] == 2'd3);
      m.d = '{DST_RES, {2'b0, j[3:2]}};
    end else if (k < 6'd22) begin
      j = k - 6'd19;
      m.a = '{SRC_PAR, 4'(j + 6'd4)};
      m.b = '{SRC_ITM, 4'(j + 6'd4)};
      m.first = 1'b1; m.last = 1'b1; m.sh24 = 1'b1; m.fwd = 1'b1;
      m.d = '{DST_RES, 4'(j + 6'd4)};
    end else if (k < 6'd28) begin
      j = k - 6'd22;
      m.a = '{SRC_QR, 4'({2'b0, cr_u(j[2:1], j[0])} + 4'd1)};
      m.b = '{SRC_VV, {2'b0, cr_v(j[2:1], j[0])}};
      m.neg = j[0]; m.first = !j[0]; m.last = j[0];
      m.d = '{DST_UV, {2'b0, j[2:1]}};
    end else if (k < 6'd31) begin
      j = k - 6'd28;
      m.a = '{SRC_UV, j[3:0]};
      m.b = '{SRC_QR, 4'd0};
      m.first = 1'b1; m.last = 1'b1;
      m.d = '{DST_RW, j[3:0]};
    end else begin
      j = k - 6'd31;
      m.a = '{SRC_QR, 4'({2'b0, cr_u(j[2:1], j[0])} + 4'd1)};
      m.b = '{SRC_UV, {2'b0, cr_v(j[2:1], j[0])}};
      m.neg = j[0]; m.first = !j[0]; m.last = j[0];
      m.d = '{DST_UUV, {2'b0, j[2:1]}};
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/spt_div.sv
`timescale 1ns / 1ps

// (n * 2^24) / d, truncated toward zero and saturated, one quotient bit a cycle
module spt_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);
  import spt_pkg::*;

  logic                busy;
  logic                fin;
  logic [5:0]          cnt;
  logic [31:0]         rem;
  logic [31:0]         dmag;
  logic [DIV_BITS-1:0] qn;
  logic                neg;
  logic [32:0]         r2;
  logic                ge;
  logic signed [32:0]  nx;
  logic signed [32:0]  dx;
  logic [32:0]         nabs;
  logic [32:0]         dabs;

  always_comb begin
    r2 = {rem, qn[DIV_BITS-1]};
    ge = (r2 >= {1'b0, dmag});
    nx = 33'(num);
    dx = 33'(den);
    nabs = (nx < 0) ? 33'(-nx) : 33'(nx);
    dabs = (dx < 0) ? 33'(-dx) : 33'(dx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      cnt <= '0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qn <= {nabs[31:0], 24'b0};
      rem <= '0;
      dmag <= dabs[31:0];
      neg <= num[31] ^ den[31];
    end else if (busy) begin
      rem <= ge ? 32'(r2 - {1'b0, dmag}) : r2[31:0];
      qn <= {qn[DIV_BITS-2:0], ge};
    end
  end

  always_comb begin
    if (!neg) begin
      quo = (|qn[DIV_BITS-1:31]) ? 32'sh7fffffff : $signed({1'b0, qn[30:0]});
    end else if ((|qn[DIV_BITS-1:32]) || (qn[31] && (|qn[30:0]))) begin
      quo = 32'sh80000000;
    end else begin
      quo = $signed(32'(-qn[31:0]));
    end
  end

  assign done = fin;

endmodule

FILE: rtl/core/skeleton_pose_transform_resolver_top.sv
`timescale 1ns / 1ps

// channel | direction | handshake           | payload
// in      | input     | in_valid/in_ready   | in_data (bone, parent, rotation, scale, move)
// out     | output    | out_valid/out_ready | out_data (bone, result transform, scale_error)
// cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one bone per transaction; in_ready is high only while the sequencer is idle
// no parent: the bone is stored directly; forward compose: 37 steps of the
//   shared 32x32 multiplier between the parent read and the store
// inverse: the multiply steps are followed by six 56-step serial divisions
// the output register lets a result wait while the next bone is taken in
// reset is synchronous; pose memory contents are undefined until written
module skeleton_pose_transform_resolver_top #(
  parameter int MAX_BONES = spt_pkg::DEF_MAX_BONES
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  spt_pkg::item_t   in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output spt_pkg::result_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [0:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import spt_pkg::*;

  localparam int DEPTH = MAX_BONES * WORDS;
  localparam int AW = $clog2(DEPTH);
  localparam logic [16:0] BONE_LIMIT = 17'(MAX_BONES);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RD    = 9'b000000010,
    S_PREP  = 9'b000000100,
    S_MAC   = 9'b000001000,
    S_DRAIN = 9'b000010000,
    S_FIN   = 9'b000100000,
    S_DIV   = 9'b001000000,
    S_WR    = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  state_t state;

  // configuration
  logic        dir;
  logic [30:0] min_scale;

  // sequencer counters
  logic [3:0] cnt;
  logic [5:0] k;
  logic [2:0] dcnt;
  logic       dbusy;
  logic       div_start;

  // transaction context
  logic [7:0]    bone;
  logic          bone_ok;
  logic [AW-1:0] pbase;
  logic [AW-1:0] bbase;
  logic          err;

  // working registers
  logic signed [31:0] par [WORDS];
  logic signed [31:0] itm [WORDS];
  logic signed [31:0] res [WORDS];
  logic signed [31:0] qr  [4];
  logic signed [31:0] vv  [3];
  logic signed [31:0] uv  [3];
  logic signed [31:0] uuv [3];
  logic signed [31:0] rw  [3];
  logic signed [31:0] rr  [3];

  // pose memory, ten words per bone
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [3:0]    rword;
  logic          mem_we;
  logic [31:0]   keep;

  logic               has_parent;
  logic [19:0]        pbase_w;
  logic [19:0]        bbase_w;
  logic signed [31:0] fields [WORDS];
  logic               bad;
  logic signed [31:0] qr_next [4];
  logic signed [31:0] vv_next [3];
  logic signed [31:0] rr_next [3];
  logic signed [31:0] mv_next [3];
  logic               accept;
  logic               load_out;

  // shared multiplier pipeline
  mop_t               mop;
  mop_t               m1;
  logic               m1_v;
  logic signed [31:0] opa;
  logic signed [31:0] opb;
  logic signed [63:0] mreg;
  logic signed [65:0] acc;
  logic signed [65:0] term;
  logic signed [65:0] acc_sum;
  logic signed [65:0] rnd;
  logic signed [65:0] shv;
  logic signed [31:0] mac_val;

  // divider hookup
  logic signed [31:0] div_num;
  logic signed [31:0] div_den;
  logic [3:0]         div_dst;
  logic               div_done;
  logic signed [31:0] div_quo;

  assign in_ready = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept = in_valid && in_ready;
  assign load_out = (state == S_DONE) && (!out_valid || out_ready);

  assign has_parent = (in_data.parent_index < NO_PARENT) &&
                      ({8'b0, in_data.parent_index} < BONE_LIMIT);
  assign pbase_w = ({11'b0, in_data.parent_index} << 3) + ({11'b0, in_data.parent_index} << 1);
  assign bbase_w = ({12'b0, in_data.bone_index} << 3) + ({12'b0, in_data.bone_index} << 1);

  assign fields[0] = in_data.rot_w;
  assign fields[1] = in_data.rot_x;
  assign fields[2] = in_data.rot_y;
  assign fields[3] = in_data.rot_z;
  assign fields[4] = in_data.scale_x;
  assign fields[5] = in_data.scale_y;
  assign fields[6] = in_data.scale_z;
  assign fields[7] = in_data.move_x;
  assign fields[8] = in_data.move_y;
  assign fields[9] = in_data.move_z;

  // memory ports: word reads while loading the parent, word writes while storing
  assign rword = (cnt > 4'd9) ? 4'd9 : cnt;
  assign raddr = pbase + AW'(rword);
  assign waddr = bbase + AW'(cnt);
  assign mem_we = (state == S_WR) && bone_ok;
  assign keep = dir ? itm[cnt] : res[cnt];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= keep;
    end
    rdata <= mem[raddr];
  end

  // parent checks and inverse setup
  always_comb begin
    logic signed [32:0] s;
    logic [32:0]        mag;
    bad = 1'b0;
    for (int i = 0; i < 3; i++) begin
      s = 33'(par[4+i]);
      mag = (s < 0) ? 33'(-s) : 33'(s);
      if ((par[4+i] == 32'sd0) || (mag < {2'b0, min_scale})) begin
        bad = dir;
      end
    end
    qr_next[0] = par[0];
    for (int i = 1; i < 4; i++) begin
      qr_next[i] = dir ? sat32(-66'(par[i])) : par[i];
    end
    for (int i = 0; i < 3; i++) begin
      vv_next[i] = sat32(66'(itm[7+i]) - 66'(par[7+i]));
    end
  end

  // rotated vector v + 2 * (w * uv + uuv), then parent translation in forward mode
  always_comb begin
    logic signed [65:0] t;
    for (int i = 0; i < 3; i++) begin
      t = 66'(rw[i]) + 66'(uuv[i]);
      rr_next[i] = sat32(66'(vv[i]) + (t <<< 1));
      mv_next[i] = sat32(66'(par[7+i]) + 66'(rr_next[i]));
    end
  end

  // operand selection for the current step
  assign mop = spt_decode(k);

  always_comb begin
    case (mop.a.grp)
      SRC_PAR: opa = par[mop.a.idx];
      SRC_ITM: opa = itm[mop.a.idx];
      SRC_QR:  opa = qr[mop.a.idx[1:0]];
      SRC_VV:  opa = vv[mop.a.idx[1:0]];
      SRC_UV:  opa = uv[mop.a.idx[1:0]];
      default: opa = '0;
    endcase
    case (mop.b.grp)
      SRC_PAR: opb = par[mop.b.idx];
      SRC_ITM: opb = itm[mop.b.idx];
      SRC_QR:  opb = qr[mop.b.idx[1:0]];
      SRC_VV:  opb = vv[mop.b.idx[1:0]];
      SRC_UV:  opb = uv[mop.b.idx[1:0]];
      default: opb = '0;
    endcase
  end

  // accumulate floored quarter products, round half up to the target format
  always_comb begin
    term = 66'(mreg >>> 2);
    acc_sum = (m1.first ? 66'sd0 : acc) + (m1.neg ? -term : term);
    rnd = acc_sum + (m1.sh24 ? 66'sd2097152 : 66'sd134217728);
    shv = m1.sh24 ? (rnd >>> 22) : (rnd >>> 28);
    mac_val = sat32(shv);
  end

  always_comb begin
    unique case (dcnt)
      3'd0: begin div_num = itm[4]; div_den = par[4]; div_dst = 4'd4; end
      3'd1: begin div_num = itm[5]; div_den = par[5]; div_dst = 4'd5; end
      3'd2: begin div_num = itm[6]; div_den = par[6]; div_dst = 4'd6; end
      3'd3: begin div_num = rr[0];  div_den = par[4]; div_dst = 4'd7; end
      3'd4: begin div_num = rr[1];  div_den = par[5]; div_dst = 4'd8; end
      3'd5: begin div_num = rr[2];  div_den = par[6]; div_dst = 4'd9; end
      default: begin div_num = itm[4]; div_den = par[4]; div_dst = 4'd4; end
    endcase
  end

  spt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dir <= 1'b0;
      min_scale <= MIN_SCALE_RST;
      out_valid <= 1'b0;
      cnt <= '0;
      k <= '0;
      dcnt <= '0;
      dbusy <= 1'b0;
      div_start <= 1'b0;
      m1_v <= 1'b0;
    end else begin
      div_start <= 1'b0;
      m1_v <= (state == S_MAC) && (!mop.fwd || !dir);
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DIRECTION: dir <= cfg_data[0];
          CFG_MIN_SCALE: min_scale <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cnt <= '0;
            k <= '0;
            dcnt <= '0;
            state <= has_parent ? S_RD : S_WR;
          end
        end
        S_RD: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd10) begin
            cnt <= '0;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          k <= '0;
          state <= bad ? S_WR : S_MAC;
        end
        S_MAC: begin
          k <= k + 6'd1;
          if (k == MAC_TERMS - 6'd1) begin
            cnt <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd1) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          cnt <= '0;
          dcnt <= '0;
          state <= dir ? S_DIV : S_WR;
        end
        S_DIV: begin
          if (!dbusy) begin
            div_start <= 1'b1;
            dbusy <= 1'b1;
          end else if (div_done) begin
            dbusy <= 1'b0;
            dcnt <= dcnt + 3'd1;
            if (dcnt == 3'd5) begin
              cnt <= '0;
              state <= S_WR;
            end
          end
        end
        S_WR: begin
          cnt <= cnt + 4'd1;
          if (cnt == 4'd9) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mreg <= opa * opb;
    m1 <= mop;
    if (m1_v) begin
      acc <= acc_sum;
    end
    if (accept) begin
      bone <= in_data.bone_index;
      bone_ok <= ({9'b0, in_data.bone_index} < BONE_LIMIT);
      pbase <= pbase_w[AW-1:0];
      bbase <= bbase_w[AW-1:0];
      err <= 1'b0;
      for (int i = 0; i < WORDS; i++) begin
        itm[i] <= fields[i];
        if (!has_parent) begin
          res[i] <= fields[i];
        end
      end
    end
    if ((state == S_RD) && (cnt != 4'd0)) begin
      par[4'(cnt - 4'd1)] <= rdata;
    end
    if (state == S_PREP) begin
      for (int i = 0; i < 4; i++) begin
        qr[i] <= qr_next[i];
      end
      for (int i = 0; i < 3; i++) begin
        vv[i] <= vv_next[i];
      end
      if (bad) begin
        err <= 1'b1;
        for (int i = 0; i < WORDS; i++) begin
          res[i] <= '0;
        end
      end
    end
    if (m1_v && m1.last) begin
      case (m1.d.grp)
        DST_RES: res[m1.d.idx] <= mac_val;
        DST_VV:  vv[m1.d.idx[1:0]] <= mac_val;
        DST_UV:  uv[m1.d.idx[1:0]] <= mac_val;
        DST_UUV: uuv[m1.d.idx[1:0]] <= mac_val;
        DST_RW:  rw[m1.d.idx[1:0]] <= mac_val;
        default: ;
      endcase
    end
    if (state == S_FIN) begin
      for (int i = 0; i < 3; i++) begin
        rr[i] <= rr_next[i];
        if (!dir) begin
          res[7+i] <= mv_next[i];
        end
      end
    end
    if ((state == S_DIV) && dbusy && div_done) begin
      res[div_dst] <= div_quo;
    end
    if (load_out) begin
      out_data.out_bone <= bone;
      out_data.out_rot_w <= res[0];
      out_data.out_rot_x <= res[1];
      out_data.out_rot_y <= res[2];
      out_data.out_rot_z <= res[3];
      out_data.out_scale_x <= res[4];
      out_data.out_scale_y <= res[5];
      out_data.out_scale_z <= res[6];
      out_data.out_move_x <= res[7];
      out_data.out_move_y <= res[8];
      out_data.out_move_z <= res[9];
      out_data.scale_error <= err;
    end
  end

endmodule

FILE: rtl/core/spt_checker.sv
`timescale 1ns / 1ps

module spt_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input spt_pkg::result_t out_data
);
  import spt_pkg::*;

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // busy after taking a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // error results carry a zero transform
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.scale_error |->
      out_data.out_rot_w == 0 && out_data.out_rot_x == 0 && out_data.out_rot_y == 0 &&
      out_data.out_rot_z == 0 && out_data.out_scale_x == 0 && out_data.out_scale_y == 0 &&
      out_data.out_scale_z == 0 && out_data.out_move_x == 0 && out_data.out_move_y == 0 &&
      out_data.out_move_z == 0)
    else $error("error result with nonzero transform");

  // reset leaves the block empty and idle
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

endmodule

bind skeleton_pose_transform_resolver_top spt_checker u_spt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
